@@ design/aps_pkg.sv @@
package aps_pkg;

  localparam int COORD_INT_BITS = 12;
  localparam int FRAC_BITS      = 8;

  localparam int POS_W   = COORD_INT_BITS + FRAC_BITS;
  localparam int PIX_W   = COORD_INT_BITS + 1;
  localparam int WT_W    = FRAC_BITS + 1;
  localparam int WGT_W   = 2 * FRAC_BITS + 1;
  localparam int CH_W    = 8;
  localparam int CP_W    = CH_W + WGT_W;
  localparam int NUM_CH  = 4;

  localparam logic [WT_W-1:0] FRAC_ONE = WT_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_XY    = 2'd1,
    MODE_X     = 2'd2,
    MODE_Y     = 2'd3
  } aps_mode_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
  } aps_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_alpha;
    logic             last;
  } aps_out_t;

  typedef struct packed {
    logic                         valid;
    logic                         last;
    logic [PIX_W-1:0]             px;
    logic [PIX_W-1:0]             py;
    logic [WT_W-1:0]              wx;
    logic [WT_W-1:0]              wy;
    logic [NUM_CH-1:0][CH_W-1:0]  rgba;
  } aps_tap_t;

endpackage

@@ design/antialiased_point_splat.sv @@
// Channel  Direction  Handshake                 Word
// point    in         start_i high, busy_o low  point_i (aps_in_t)
// pixel    out        pixel_valid_o, one cycle  pixel_o (aps_out_t)
//
// One point gives one, two or four pixel words, one per cycle, and occupies
// the sequencer while they are issued; busy_o is low on its last pixel.
// The first pixel passes the point register, weight select, weight product
// and channel product registers after the point is taken.
// Reset clears the valid bits only. The pixel side has no back-pressure.
module antialiased_point_splat (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  aps_pkg::aps_in_t  point_i,
  output logic              busy_o,
  output logic              pixel_valid_o,
  output aps_pkg::aps_out_t pixel_o
);
  import aps_pkg::*;

  aps_tap_t tap;

  logic                        wv_q, wl_q;
  logic [PIX_W-1:0]            wpx_q, wpy_q;
  logic [WGT_W-1:0]            w_q;
  logic [NUM_CH-1:0][CH_W-1:0] wrgba_q;
  logic [2*WT_W-1:0]           w_full;

  logic                        ov_q;
  aps_out_t                    o_q, o_d;
  logic [NUM_CH-1:0][CP_W-1:0] prod;

  aps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .item_i (point_i),
    .busy_o (busy_o),
    .tap_o  (tap)
  );

  assign w_full = tap.wx * tap.wy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      wv_q <= tap.valid;
      ov_q <= wv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wl_q    <= tap.last;
    wpx_q   <= tap.px;
    wpy_q   <= tap.py;
    w_q     <= w_full[WGT_W-1:0];
    wrgba_q <= tap.rgba;
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = CP_W'(wrgba_q[c]) * CP_W'(w_q);
    end
    o_d.pixel_x   = wpx_q;
    o_d.pixel_y   = wpy_q;
    o_d.out_red   = prod[0][2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    o_d.out_green = prod[1][2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    o_d.out_blue  = prod[2][2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    o_d.out_alpha = prod[3][2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    o_d.last      = wl_q;
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d;
  end

  assign pixel_valid_o = ov_q;
  assign pixel_o       = o_q;

endmodule

@@ design/aps_seq.sv @@
module aps_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  aps_pkg::aps_in_t item_i,
  output logic            busy_o,
  output aps_pkg::aps_tap_t tap_o
);
  import aps_pkg::*;

  logic      hold_q, hold_d;
  aps_in_t   item_q, item_d;
  logic      i_q, i_d, j_q, j_d;
  aps_tap_t  tap_q, tap_d;

  aps_mode_e            mode;
  logic [FRAC_BITS-1:0] fx, fy;
  logic                 x2, y2, nxt_x, nxt_y, last, accept;

  always_comb begin
    mode  = aps_mode_e'(item_q.mode);
    fx    = item_q.x_pos[FRAC_BITS-1:0];
    fy    = item_q.y_pos[FRAC_BITS-1:0];
    if (mode == MODE_PLAIN || mode == MODE_Y) fx = '0;
    if (mode == MODE_PLAIN || mode == MODE_X) fy = '0;
    x2    = |fx;
    y2    = |fy;
    nxt_x = !i_q && x2;
    nxt_y = !j_q && y2;
    last  = !nxt_x && !nxt_y;
  end

  assign busy_o = hold_q && !last;
  assign accept = start_i && !busy_o;

  always_comb begin
    hold_d = hold_q;
    item_d = item_q;
    i_d    = i_q;
    j_d    = j_q;
    if (accept) begin
      hold_d = 1'b1;
      item_d = item_i;
      i_d    = 1'b0;
      j_d    = 1'b0;
    end else if (hold_q && !last) begin
      if (nxt_x) begin
        i_d = 1'b1;
      end else begin
        i_d = 1'b0;
        j_d = 1'b1;
      end
    end else begin
      hold_d = 1'b0;
    end
  end

  always_comb begin
    tap_d.valid = hold_q;
    tap_d.last  = last;
    tap_d.px    = {1'b0, item_q.x_pos[POS_W-1:FRAC_BITS]} + PIX_W'(i_q);
    tap_d.py    = {1'b0, item_q.y_pos[POS_W-1:FRAC_BITS]} + PIX_W'(j_q);
    tap_d.wx    = i_q ? {1'b0, fx} : FRAC_ONE - {1'b0, fx};
    tap_d.wy    = j_q ? {1'b0, fy} : FRAC_ONE - {1'b0, fy};
    tap_d.rgba  = {item_q.alpha, item_q.blue, item_q.green, item_q.red};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      tap_q.valid <= 1'b0;
    end else begin
      hold_q <= hold_d;
      tap_q  <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    i_q    <= i_d;
    j_q    <= j_d;
  end

  assign tap_o = tap_q;

endmodule

@@ design/aps_checker.sv @@
module aps_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              pixel_valid_o,
  input aps_pkg::aps_out_t pixel_o
);

  // accepted point shows its first pixel after the fixed latency
  a_accept_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 pixel_valid_o)
    else $error("no pixel after accepted point");

  // busy means a pixel of the same point is still to follow
  a_busy_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ##3 (pixel_valid_o && !pixel_o.last))
    else $error("busy without pending pixel");

  // pixels of one point come out without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && !pixel_o.last) |=> pixel_valid_o)
    else $error("gap inside pixel burst");

endmodule

bind antialiased_point_splat aps_checker u_aps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .pixel_valid_o(pixel_valid_o),
  .pixel_o      (pixel_o)
);

@@ tb/antialiased_point_splat_tb.sv @@
module antialiased_point_splat_tb;
  import aps_pkg::*;

  typedef struct {
    aps_in_t  pt;
    bit       typed;
    aps_out_t pix;
  } splat_row_t;

  localparam int NUM_ROWS     = 16;
  localparam int NUM_RANDOM   = 480;
  localparam int STALL_LIMIT  = 200;
  localparam int DRAIN_CYCLES = 10;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  aps_in_t  point_i = '0;
  logic     busy_o;
  logic     pixel_valid_o;
  aps_out_t pixel_o;

  aps_out_t   pending_pixels[$];
  aps_out_t   pix_exp;
  splat_row_t point_table[NUM_ROWS];
  int         err_cnt     = 0;
  int         points_sent = 0;
  int         pixels_seen = 0;
  int         idle_cycles = 0;

  antialiased_point_splat i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .point_i       (point_i),
    .busy_o        (busy_o),
    .pixel_valid_o (pixel_valid_o),
    .pixel_o       (pixel_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CH_W-1:0] scale_chan(input logic [CH_W-1:0] ch,
                                                 input logic [WGT_W-1:0] wgt);
    logic [CP_W-1:0] prod;
    prod = CP_W'(ch) * CP_W'(wgt);
    return CH_W'(prod >> (2 * FRAC_BITS));
  endfunction

  function automatic void splat_pixels(input aps_in_t p);
    aps_mode_e            mode;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     ix;
    logic [PIX_W-1:0]     iy;
    logic [WT_W-1:0]      wx[2];
    logic [WT_W-1:0]      wy[2];
    logic [WGT_W-1:0]     wgt;
    int                   nx;
    int                   ny;
    aps_out_t             pix;
    mode = aps_mode_e'(p.mode);
    ix   = PIX_W'(p.x_pos[POS_W-1:FRAC_BITS]);
    iy   = PIX_W'(p.y_pos[POS_W-1:FRAC_BITS]);
    fx   = p.x_pos[FRAC_BITS-1:0];
    fy   = p.y_pos[FRAC_BITS-1:0];
    if (mode == MODE_PLAIN || mode == MODE_Y) fx = '0;
    if (mode == MODE_PLAIN || mode == MODE_X) fy = '0;
    nx    = (fx == '0) ? 1 : 2;
    ny    = (fy == '0) ? 1 : 2;
    wx[0] = FRAC_ONE - WT_W'(fx);
    wx[1] = WT_W'(fx);
    wy[0] = FRAC_ONE - WT_W'(fy);
    wy[1] = WT_W'(fy);
    for (int j = 0; j < ny; j++) begin
      for (int i = 0; i < nx; i++) begin
        wgt           = WGT_W'(wx[i]) * WGT_W'(wy[j]);
        pix.pixel_x   = ix + PIX_W'(i);
        pix.pixel_y   = iy + PIX_W'(j);
        pix.out_red   = scale_chan(p.red, wgt);
        pix.out_green = scale_chan(p.green, wgt);
        pix.out_blue  = scale_chan(p.blue, wgt);
        pix.out_alpha = scale_chan(p.alpha, wgt);
        pix.last      = (i == nx - 1) && (j == ny - 1);
        pending_pixels.push_back(pix);
      end
    end
  endfunction

  function automatic logic [POS_W-1:0] rand_coord();
    logic [POS_W-1:0] c;
    c = POS_W'($urandom);
    case ($urandom_range(0, 7))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[POS_W-1:FRAC_BITS] = '1;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic aps_in_t rand_point();
    aps_in_t p;
    p.mode  = 2'($urandom_range(0, 3));
    p.x_pos = rand_coord();
    p.y_pos = rand_coord();
    p.red   = rand_chan();
    p.green = rand_chan();
    p.blue  = rand_chan();
    p.alpha = rand_chan();
    return p;
  endfunction

  // hold the word until busy_o drops, then record what it must produce
  task automatic send_point(input aps_in_t p, input bit typed, input aps_out_t pix);
    start_i <= 1'b1;
    point_i <= p;
    do @(posedge clk_i); while (busy_o);
    if (typed) pending_pixels.push_back(pix);
    else splat_pixels(p);
    points_sent++;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_pixels();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pixel_valid_o) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pixel word x=%0d y=%0d rgba=%h_%h_%h_%h last=%0b",
                 $time, pixel_o.pixel_x, pixel_o.pixel_y, pixel_o.out_red,
                 pixel_o.out_green, pixel_o.out_blue, pixel_o.out_alpha, pixel_o.last);
      end else begin
        pix_exp = pending_pixels.pop_front();
        if (pixel_o.pixel_x !== pix_exp.pixel_x || pixel_o.pixel_y !== pix_exp.pixel_y ||
            pixel_o.out_red !== pix_exp.out_red || pixel_o.out_green !== pix_exp.out_green ||
            pixel_o.out_blue !== pix_exp.out_blue ||
            pixel_o.out_alpha !== pix_exp.out_alpha || pixel_o.last !== pix_exp.last) begin
          err_cnt++;
          $display("%0t: pixel mismatch exp x=%0d y=%0d rgba=%h_%h_%h_%h last=%0b",
                   $time, pix_exp.pixel_x, pix_exp.pixel_y, pix_exp.out_red,
                   pix_exp.out_green, pix_exp.out_blue, pix_exp.out_alpha, pix_exp.last);
          $display("%0t:                got x=%0d y=%0d rgba=%h_%h_%h_%h last=%0b",
                   $time, pixel_o.pixel_x, pixel_o.pixel_y, pixel_o.out_red,
                   pixel_o.out_green, pixel_o.out_blue, pixel_o.out_alpha, pixel_o.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || pixel_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int burst_left;
    burst_left = 0;
    point_table = '{
      '{{MODE_PLAIN, 20'h00000, 20'h00000, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
        {13'd0, 13'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1}},
      '{{MODE_PLAIN, 20'hfffff, 20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
        {13'd4095, 13'd4095, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1}},
      '{{MODE_XY, 20'h12300, 20'h04500, 8'ha5, 8'h5a, 8'h3c, 8'hc3}, 1'b1,
        {13'h123, 13'h045, 8'ha5, 8'h5a, 8'h3c, 8'hc3, 1'b1}},
      '{{MODE_XY, 20'hfffff, 20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_XY, 20'h00180, 20'h00080, 8'hff, 8'h80, 8'h01, 8'h00}, 1'b0, '0},
      '{{MODE_XY, 20'h00201, 20'h00301, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_X, 20'h00a40, 20'h00b7f, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b0, '0},
      '{{MODE_X, 20'h00500, 20'h003ff, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b1,
        {13'd5, 13'd3, 8'h80, 8'h80, 8'h80, 8'h80, 1'b1}},
      '{{MODE_Y, 20'h00c33, 20'h00dc0, 8'hff, 8'h00, 8'hff, 8'h00}, 1'b0, '0},
      '{{MODE_Y, 20'h007c1, 20'h00900, 8'h11, 8'h22, 8'h33, 8'h44}, 1'b1,
        {13'd7, 13'd9, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1}},
      '{{MODE_XY, 20'h00400, 20'h00440, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_XY, 20'h004c0, 20'h00400, 8'hfe, 8'hfd, 8'hfc, 8'hfb}, 1'b0, '0},
      '{{MODE_XY, 20'h00555, 20'h00aaa, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_X, 20'hfffff, 20'h00000, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_Y, 20'h00000, 20'hfffff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_PLAIN, 20'h3ffff, 20'h5ab80, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (point_table[r]) begin
      idle_for($urandom_range(0, 3));
      send_point(point_table[r].pt, point_table[r].typed, point_table[r].pix);
    end
    drain_pixels();

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM / 2) drain_pixels();
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      end
      send_point(rand_point(), 1'b0, '0);
      burst_left--;
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d pixel words never arrived", $time, pending_pixels.size());
    end

    $display("Sent %0d points (%0d table rows, the rest random in bursts, all modes)",
             points_sent, NUM_ROWS);
    $display("Checked %0d pixel words, %0d errors", pixels_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/aps_pkg.sv
design/aps_seq.sv
design/antialiased_point_splat.sv
design/aps_checker.sv
tb/antialiased_point_splat_tb.sv
